FILE: sv/rotary_arm_kinematic_transform_unit_assert.svh
// Assertion macros for the rotary arm kinematic transform unit.
// Included by modules that carry concurrent assertions; no other dependency.
`ifndef ROTARY_ARM_KINEMATIC_TRANSFORM_UNIT_ASSERT_SVH
`define ROTARY_ARM_KINEMATIC_TRANSFORM_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define RAKT_ASSERT_NOW(LBL, CLK, RSTN, ANT, CONS) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANT) |-> (CONS)) \
        else $error("rakt assertion failed");

// Next-cycle implication, checked out of reset.
`define RAKT_ASSERT_NEXT(LBL, CLK, RSTN, ANT, CONS) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANT) |=> (CONS)) \
        else $error("rakt assertion failed");

`endif

FILE: sv/rakt_pkg.sv
// Package for the rotary arm kinematic transform unit: types, constants, saturation.
// No dependencies.
package rakt_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned MOD_CELLS = 28;
    localparam int unsigned ATAN_LEN  = 30;

    localparam logic signed [35:0] PI_Q32      = 36'sd13493037705;
    localparam logic signed [35:0] TWO_PI_Q32  = 36'sd26986075410;
    localparam logic signed [35:0] HALF_PI_Q32 = 36'sd6746518852;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

    localparam logic signed [31:0] ATAN_Q30 [ATAN_LEN] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001
    };

    typedef enum logic [2:0] {
        CFG_ARM_RADIUS   = 3'd0,
        CFG_X_SHIFT      = 3'd1,
        CFG_Y_SHIFT      = 3'd2,
        CFG_ANGLE_OUT    = 3'd3,
        CFG_ANGLE_IN     = 3'd4,
        CFG_ANGLE_TO_RAD = 3'd5,
        CFG_RATE_SCALE   = 3'd6
    } t_cfg_idx;

    // Item fields that ride alongside the angle datapath
    typedef struct packed {
        logic              op;
        logic signed [31:0] xp;
        logic signed [31:0] yp;
        logic signed [31:0] a;
        logic signed [31:0] xv;
        logic signed [31:0] yv;
        logic signed [31:0] av;
        logic signed [31:0] v;
    } t_side;

    // Angle magnitude under reduction, with the sign of the raw product
    typedef struct packed {
        logic        neg;
        logic [62:0] mag;
    } t_red;

    // CORDIC rotation lane
    typedef struct packed {
        logic               neg;
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
    } t_rot;

    function automatic logic signed [31:0] sat(input logic signed [65:0] v);
        logic signed [31:0] res;
        if (v > 66'sd2147483647) begin
            res = 32'sh7FFFFFFF;
        end else if (v < -66'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

FILE: sv/rakt_in_if.sv
// Input channel of the rotary arm kinematic transform unit: valid, ready, item fields.
// No dependencies.
interface rakt_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [31:0] in_x_pos;
    logic signed [31:0] in_y_pos;
    logic signed [31:0] in_angle;
    logic signed [31:0] in_x_vel;
    logic signed [31:0] in_y_vel;
    logic signed [31:0] in_angle_vel;

    modport source (output valid, op, in_x_pos, in_y_pos, in_angle, in_x_vel, in_y_vel,
                    in_angle_vel, input ready);
    modport sink   (input valid, op, in_x_pos, in_y_pos, in_angle, in_x_vel, in_y_vel,
                    in_angle_vel, output ready);
endinterface

FILE: sv/rakt_out_if.sv
// Output channel of the rotary arm kinematic transform unit: valid, ready, result fields.
// No dependencies.
interface rakt_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x_pos;
    logic signed [31:0] out_y_pos;
    logic signed [31:0] out_angle;
    logic signed [31:0] out_x_vel;
    logic signed [31:0] out_y_vel;
    logic signed [31:0] out_angle_vel;

    modport source (output valid, out_x_pos, out_y_pos, out_angle, out_x_vel, out_y_vel,
                    out_angle_vel, input ready);
    modport sink   (input valid, out_x_pos, out_y_pos, out_angle, out_x_vel, out_y_vel,
                    out_angle_vel, output ready);
endinterface

FILE: sv/rakt_mod_cell.sv
// One compare-and-subtract cell of the angle range reduction chain.
// Depends on rakt_pkg.
module rakt_mod_cell import rakt_pkg::*; #(
    parameter int unsigned SHIFT = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_vld,
    input  t_red  i_red,
    input  t_side i_side,
    output logic  o_vld,
    output t_red  o_red,
    output t_side o_side
);
    localparam logic [62:0] STEP = 63'(TWO_PI_Q32) << SHIFT;

    logic  r_vld;
    t_red  r_red;
    t_side r_side;
    t_red  n_red;

    always_comb begin
        n_red = i_red;
        if (i_red.mag >= STEP) begin
            n_red.mag = i_red.mag - STEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_red  <= n_red;
            r_side <= i_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_red  = r_red;
    assign o_side = r_side;
endmodule

FILE: sv/rakt_cordic_cell.sv
// One rotation step of the CORDIC chain, with a fixed shift and arctangent.
// Depends on rakt_pkg.
module rakt_cordic_cell import rakt_pkg::*; #(
    parameter int unsigned IDX = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_vld,
    input  t_rot  i_rot,
    input  t_side i_side,
    output logic  o_vld,
    output t_rot  o_rot,
    output t_side o_side
);
    localparam logic signed [33:0] ANG = 34'(ATAN_Q30[IDX]);

    logic  r_vld;
    t_rot  r_rot;
    t_side r_side;
    t_rot  n_rot;

    always_comb begin
        n_rot = i_rot;
        if (!i_rot.z[33]) begin
            n_rot.x = i_rot.x - (i_rot.y >>> IDX);
            n_rot.y = i_rot.y + (i_rot.x >>> IDX);
            n_rot.z = i_rot.z - ANG;
        end else begin
            n_rot.x = i_rot.x + (i_rot.y >>> IDX);
            n_rot.y = i_rot.y - (i_rot.x >>> IDX);
            n_rot.z = i_rot.z + ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rot  <= n_rot;
            r_side <= i_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_rot  = r_rot;
    assign o_side = r_side;
endmodule

FILE: sv/rotary_arm_kinematic_transform_unit.sv
// Top level of the rotary arm kinematic transform unit.
// Depends on rakt_pkg, rakt_in_if, rakt_out_if, rakt_mod_cell, rakt_cordic_cell
// and the assertion header.
//
// Polar to Cartesian transform for a rotary arm, one servo sample per transfer.
// op = 0 (forward): offset the angle, take its sine and cosine by CORDIC and add
// the arm contribution (radius times cos/sin, and its rate term) to x and y.
// op = 1 (inverse): remove that contribution from x and y feedback. All values are
// Q16.16 signed and results saturate. The unit is fully pipelined: it takes one
// transfer every cycle while the output is not stalled. The pipeline is made of
// the 28-cell angle reduction chain and the CORDIC_STEPS rotation cells, plus
// front multiply and back multiply stages.
// The whole pipeline holds while a finished result waits on the output, so ready
// drops only in that case. Write configuration only while the unit is empty.
`include "rotary_arm_kinematic_transform_unit_assert.svh"

module rotary_arm_kinematic_transform_unit import rakt_pkg::*; #(
    parameter int unsigned CORDIC_STEPS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rakt_in_if.sink           i_in,
    rakt_out_if.source        o_out,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [DATA_W-1:0] i_cfg_data
);
    // ---------------- configuration registers ----------------
    logic signed [31:0] r_arm_radius, r_x_shift, r_y_shift, r_ang_out, r_ang_in;
    logic signed [31:0] r_ang_to_rad, r_rate_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arm_radius <= '0;
            r_x_shift    <= '0;
            r_y_shift    <= '0;
            r_ang_out    <= '0;
            r_ang_in     <= '0;
            r_ang_to_rad <= 32'sd65536;
            r_rate_scale <= 32'sd65536;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ARM_RADIUS:   r_arm_radius <= i_cfg_data;
                CFG_X_SHIFT:      r_x_shift    <= i_cfg_data;
                CFG_Y_SHIFT:      r_y_shift    <= i_cfg_data;
                CFG_ANGLE_OUT:    r_ang_out    <= i_cfg_data;
                CFG_ANGLE_IN:     r_ang_in     <= i_cfg_data;
                CFG_ANGLE_TO_RAD: r_ang_to_rad <= i_cfg_data;
                CFG_RATE_SCALE:   r_rate_scale <= i_cfg_data;
                default:          ; // unknown index: drop the write
            endcase
        end
    end

    // ---------------- pipeline advance ----------------
    // Advance everything together unless the output register holds an untaken result.
    logic w_en;
    logic r_out_vld;
    assign w_en       = !r_out_vld || o_out.ready;
    assign i_in.ready = w_en;

    // ---------------- front: offset angle ----------------
    logic  r_s0_vld;
    t_side r_s0_side;
    t_side n_s0_side;

    always_comb begin
        n_s0_side.op = i_in.op;
        n_s0_side.xp = i_in.in_x_pos;
        n_s0_side.yp = i_in.in_y_pos;
        n_s0_side.xv = i_in.in_x_vel;
        n_s0_side.yv = i_in.in_y_vel;
        n_s0_side.av = i_in.in_angle_vel;
        n_s0_side.v  = '0;
        if (i_in.op) begin
            n_s0_side.a = sat(66'(i_in.in_angle) - 66'(r_ang_out));
        end else begin
            n_s0_side.a = sat(66'(i_in.in_angle) + 66'(r_ang_in));
        end
    end

    // ---------------- front: angle and rate products ----------------
    logic               r_s1_vld;
    t_side              r_s1_side;
    logic signed [63:0] r_s1_theta, r_s1_vprod;

    // ---------------- front: rate saturate, angle magnitude ----------------
    logic  r_s2_vld;
    t_side r_s2_side;
    t_red  r_s2_red;
    t_side n_s2_side;
    t_red  n_s2_red;

    always_comb begin
        n_s2_side   = r_s1_side;
        n_s2_side.v = sat(66'(r_s1_vprod));
        n_s2_red.neg = r_s1_theta[63];
        n_s2_red.mag = r_s1_theta[63] ? 63'(-r_s1_theta) : r_s1_theta[62:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else if (w_en) begin
            r_s0_vld <= i_in.valid;
            r_s1_vld <= r_s0_vld;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_side  <= n_s0_side;
            r_s1_side  <= r_s0_side;
            r_s1_theta <= 64'(r_s0_side.a) * 64'(r_ang_to_rad);
            r_s1_vprod <= 64'(r_s0_side.av) * 64'(r_rate_scale);
            r_s2_side  <= n_s2_side;
            r_s2_red   <= n_s2_red;
        end
    end

    // ---------------- reduction chain: magnitude modulo two pi ----------------
    logic  w_mvld  [MOD_CELLS+1];
    t_red  w_mred  [MOD_CELLS+1];
    t_side w_mside [MOD_CELLS+1];

    assign w_mvld[0]  = r_s2_vld;
    assign w_mred[0]  = r_s2_red;
    assign w_mside[0] = r_s2_side;

    for (genvar g = 0; g < MOD_CELLS; g++) begin : g_mod
        rakt_mod_cell #(.SHIFT(MOD_CELLS - 1 - g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_vld  (w_mvld[g]),
            .i_red  (w_mred[g]),
            .i_side (w_mside[g]),
            .o_vld  (w_mvld[g+1]),
            .o_red  (w_mred[g+1]),
            .o_side (w_mside[g+1])
        );
    end

    // ---------------- fold into [-pi/2, pi/2] ----------------
    logic               r_f1_vld, r_f2_vld, r_f3_vld;
    t_side              r_f1_side, r_f2_side, r_f3_side;
    logic signed [35:0] r_f1_r, r_f2_r;
    logic signed [35:0] n_f1_r, n_f2_r, w_f3_r;
    t_rot               r_f3_rot, n_f3_rot;

    always_comb begin
        // restore the sign with a truncating remainder, then lift negatives by two pi
        if (w_mred[MOD_CELLS].neg && (w_mred[MOD_CELLS].mag != '0)) begin
            n_f1_r = TWO_PI_Q32 - $signed({1'b0, w_mred[MOD_CELLS].mag[34:0]});
        end else begin
            n_f1_r = $signed({1'b0, w_mred[MOD_CELLS].mag[34:0]});
        end
        n_f2_r = (r_f1_r >= PI_Q32) ? r_f1_r - TWO_PI_Q32 : r_f1_r;
        n_f3_rot.x   = GAIN_Q30;
        n_f3_rot.y   = '0;
        n_f3_rot.neg = 1'b0;
        w_f3_r       = r_f2_r;
        if (r_f2_r > HALF_PI_Q32) begin
            w_f3_r       = r_f2_r - PI_Q32;
            n_f3_rot.neg = 1'b1;
        end else if (r_f2_r < -HALF_PI_Q32) begin
            w_f3_r       = r_f2_r + PI_Q32;
            n_f3_rot.neg = 1'b1;
        end
        n_f3_rot.z = 34'(w_f3_r >>> 2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
            r_f2_vld <= 1'b0;
            r_f3_vld <= 1'b0;
        end else if (w_en) begin
            r_f1_vld <= w_mvld[MOD_CELLS];
            r_f2_vld <= r_f1_vld;
            r_f3_vld <= r_f2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f1_side <= w_mside[MOD_CELLS];
            r_f1_r    <= n_f1_r;
            r_f2_side <= r_f1_side;
            r_f2_r    <= n_f2_r;
            r_f3_side <= r_f2_side;
            r_f3_rot  <= n_f3_rot;
        end
    end

    // ---------------- CORDIC rotation chain ----------------
    logic  w_cvld  [CORDIC_STEPS+1];
    t_rot  w_crot  [CORDIC_STEPS+1];
    t_side w_cside [CORDIC_STEPS+1];

    assign w_cvld[0]  = r_f3_vld;
    assign w_crot[0]  = r_f3_rot;
    assign w_cside[0] = r_f3_side;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        rakt_cordic_cell #(.IDX(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_vld  (w_cvld[g]),
            .i_rot  (w_crot[g]),
            .i_side (w_cside[g]),
            .o_vld  (w_cvld[g+1]),
            .o_rot  (w_crot[g+1]),
            .o_side (w_cside[g+1])
        );
    end

    // ---------------- back end: arm terms and rate terms ----------------
    logic               r_n_vld, r_m1_vld, r_m2_vld, r_m3_vld;
    t_side              r_n_side, r_m1_side, r_m2_side, r_m3_side;
    logic signed [33:0] r_n_c, r_n_s;
    logic signed [65:0] r_m1_pc, r_m1_ps;
    logic signed [63:0] r_m1_pw;
    logic signed [31:0] r_m2_rc, r_m2_rs, r_m2_w;
    logic signed [63:0] r_m3_tc, r_m3_ts;
    logic signed [31:0] r_m3_rc, r_m3_rs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_vld  <= 1'b0;
            r_m1_vld <= 1'b0;
            r_m2_vld <= 1'b0;
            r_m3_vld <= 1'b0;
        end else if (w_en) begin
            r_n_vld  <= w_cvld[CORDIC_STEPS];
            r_m1_vld <= r_n_vld;
            r_m2_vld <= r_m1_vld;
            r_m3_vld <= r_m2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // undo the half-turn fold
            r_n_side  <= w_cside[CORDIC_STEPS];
            r_n_c     <= w_crot[CORDIC_STEPS].neg ? -w_crot[CORDIC_STEPS].x
                                                  :  w_crot[CORDIC_STEPS].x;
            r_n_s     <= w_crot[CORDIC_STEPS].neg ? -w_crot[CORDIC_STEPS].y
                                                  :  w_crot[CORDIC_STEPS].y;
            r_m1_side <= r_n_side;
            r_m1_pc   <= 66'(r_arm_radius) * 66'(r_n_c);
            r_m1_ps   <= 66'(r_arm_radius) * 66'(r_n_s);
            r_m1_pw   <= 64'(r_n_side.v) * 64'(r_ang_to_rad);
            r_m2_side <= r_m1_side;
            r_m2_rc   <= sat(r_m1_pc >>> 30);
            r_m2_rs   <= sat(r_m1_ps >>> 30);
            r_m2_w    <= sat(66'(r_m1_pw >>> 16));
            r_m3_side <= r_m2_side;
            r_m3_rc   <= r_m2_rc;
            r_m3_rs   <= r_m2_rs;
            r_m3_tc   <= 64'(r_m2_rc) * 64'(r_m2_w);
            r_m3_ts   <= 64'(r_m2_rs) * 64'(r_m2_w);
        end
    end

    // ---------------- output register ----------------
    logic signed [31:0] r_o_xp, r_o_yp, r_o_a, r_o_xv, r_o_yv, r_o_av;
    logic signed [31:0] n_o_xp, n_o_yp, n_o_a, n_o_xv, n_o_yv;
    logic signed [65:0] w_tc, w_ts;

    always_comb begin
        w_tc = 66'(r_m3_tc >>> 16);
        w_ts = 66'(r_m3_ts >>> 16);
        if (!r_m3_side.op) begin
            n_o_xp = sat(66'(r_m3_side.xp) + 66'(r_x_shift) + 66'(r_m3_rc));
            n_o_yp = sat(66'(r_m3_side.yp) + 66'(r_y_shift) + 66'(r_m3_rs));
            n_o_a  = sat(66'(r_m3_side.a) + 66'(r_ang_out));
            n_o_xv = sat(66'(r_m3_side.xv) - w_ts);
            n_o_yv = sat(66'(r_m3_side.yv) + w_tc);
        end else begin
            n_o_xp = sat(66'(r_m3_side.xp) - 66'(r_x_shift) - 66'(r_m3_rc));
            n_o_yp = sat(66'(r_m3_side.yp) - 66'(r_y_shift) - 66'(r_m3_rs));
            n_o_a  = sat(66'(r_m3_side.a) - 66'(r_ang_in));
            n_o_xv = sat(66'(r_m3_side.xv) + w_ts);
            n_o_yv = sat(66'(r_m3_side.yv) - w_tc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_m3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_xp <= n_o_xp;
            r_o_yp <= n_o_yp;
            r_o_a  <= n_o_a;
            r_o_xv <= n_o_xv;
            r_o_yv <= n_o_yv;
            r_o_av <= r_m3_side.av;
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.out_x_pos     = r_o_xp;
    assign o_out.out_y_pos     = r_o_yp;
    assign o_out.out_angle     = r_o_a;
    assign o_out.out_x_vel     = r_o_xv;
    assign o_out.out_y_vel     = r_o_yv;
    assign o_out.out_angle_vel = r_o_av;

    // ---------------- assertions ----------------
    // a waiting result must stall the input side
    `RAKT_ASSERT_NOW(a_stall_blocks_input, i_clk, i_rst_n, r_out_vld && !o_out.ready, !i_in.ready)
    // the reduction chain must leave less than one full turn
    `RAKT_ASSERT_NOW(a_reduced_below_turn, i_clk, i_rst_n, w_mvld[MOD_CELLS], w_mred[MOD_CELLS].mag < 63'(TWO_PI_Q32))
    // folded angle stays within a quarter turn either side
    `RAKT_ASSERT_NOW(a_fold_in_range, i_clk, i_rst_n, r_f3_vld, (r_f3_rot.z[33] == r_f3_rot.z[32]) && (r_f3_rot.z[32] == r_f3_rot.z[31]))
    // the valid flag of the last rotation stage holds while stalled
    `RAKT_ASSERT_NEXT(a_hold_when_stalled, i_clk, i_rst_n, !w_en, $stable(w_cvld[CORDIC_STEPS]))
endmodule
